>>> sv/ocenv_pkg.sv
package ocenv_pkg;

  localparam int LIGHT_W  = 17;
  localparam int COEFF_W  = 25;
  localparam int WEIGHT_W = 17;
  localparam int OUT_W    = 16;
  localparam int LEVEL_W  = 32;
  localparam int IDX_W    = 3;
  localparam int FRAC_C   = 24;

  localparam logic [COEFF_W-1:0]  COEFF_ONE  = 25'h100_0000;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h1_0000;
  localparam logic [OUT_W-1:0]    LIGHT_ONE  = 16'h8000;

  typedef enum logic [IDX_W-1:0] {
    REG_ATTACK     = 3'd0,
    REG_FAST_REL   = 3'd1,
    REG_SLOW_ATK   = 3'd2,
    REG_MEM_RISE   = 3'd3,
    REG_MEM_FALL   = 3'd4,
    REG_FAST_WEIGHT = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_FOLLOW,
    ST_BLEND,
    ST_MIX,
    ST_FINISH
  } state_t;

  function automatic logic [COEFF_W-1:0] sat_coeff(input logic [COEFF_W-1:0] c);
    return (c > COEFF_ONE) ? COEFF_ONE : c;
  endfunction

endpackage

>>> sv/ocenv_if.sv
interface ocenv_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [ocenv_pkg::LIGHT_W-1:0]   target_light;
  logic        [ocenv_pkg::COEFF_W-1:0]   slow_release_coeff;

  modport source (output valid, output target_light, output slow_release_coeff,
                  input ready);
  modport sink   (input valid, input target_light, input slow_release_coeff,
                  output ready);
endinterface

interface ocenv_out_if;
  logic                          valid;
  logic                          ready;
  logic [ocenv_pkg::OUT_W-1:0]   blended_light;
  logic [ocenv_pkg::OUT_W-1:0]   memory_level;

  modport source (output valid, output blended_light, output memory_level, input ready);
  modport sink   (input valid, input blended_light, input memory_level, output ready);
endinterface

interface ocenv_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ocenv_pkg::IDX_W-1:0]     index;
  logic [ocenv_pkg::COEFF_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/optical_cell_envelope.sv
// channel | dir | payload                                   | beat
// in_bus  | in  | target_light[16:0] s, slow_release_coeff  | valid & ready
// out_bus | out | blended_light[15:0], memory_level[15:0]    | valid & ready
// cfg_bus | in  | index[2:0], data[24:0]                    | valid & ready (ready tied high)
//
// From the input beat, three shift-add multipliers scan the 25 coefficient bits MSB first
// for the three cells, then two of them scan the weight for the blend. One item is in
// flight at a time; the input is ready in idle even while an earlier result waits in the
// output register.
// Synchronous active-low reset clears the cell levels and loads the default registers.
// A stalled result holds the finished item in its last state until the slot frees.
module optical_cell_envelope (
  input logic           clk,
  input logic           rst_n,
  ocenv_in_if.sink      in_bus,
  ocenv_out_if.source   out_bus,
  ocenv_cfg_if.sink     cfg_bus
);

  localparam int LW = ocenv_pkg::LEVEL_W;
  localparam int CW = ocenv_pkg::COEFF_W;
  localparam int PW = LW + CW;
  localparam int NCELL = 3;

  ocenv_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] attack_r, fast_rel_r, slow_atk_r, mem_rise_r, mem_fall_r;
  logic [ocenv_pkg::WEIGHT_W-1:0] weight_r;

  logic [LW-1:0] lvl_r [NCELL];
  logic [LW-1:0] lvl_nxt [NCELL];
  logic [ocenv_pkg::OUT_W-1:0] tgt_r;
  logic [CW-1:0] srel_r;
  logic [NCELL-1:0] rise_r;

  logic out_valid_r;
  logic [ocenv_pkg::OUT_W-1:0] blend_r, memlvl_r;

  logic [LW-1:0] target;
  logic [CW-1:0] rise_c [NCELL];
  logic [CW-1:0] fall_c [NCELL];
  logic [NCELL-1:0] rise_now;
  logic [LW-1:0] diff [NCELL];

  logic [LW-1:0] mul_a [NCELL];
  logic [CW-1:0] mul_b [NCELL];
  logic [PW-1:0] mul_p [NCELL];
  logic [NCELL-1:0] mul_start;
  logic [NCELL-1:0] mul_busy;
  logic any_busy;

  logic [ocenv_pkg::WEIGHT_W-1:0] w_sat, w_inv;
  logic [47:0] mix_sum;

  logic in_take, out_load, lvl_upd;

  assign target = {tgt_r, 16'b0};
  assign rise_c[0] = attack_r;
  assign rise_c[1] = slow_atk_r;
  assign rise_c[2] = mem_rise_r;
  assign fall_c[0] = fast_rel_r;
  assign fall_c[1] = srel_r;
  assign fall_c[2] = mem_fall_r;

  assign w_sat = (weight_r > ocenv_pkg::WEIGHT_ONE) ? ocenv_pkg::WEIGHT_ONE : weight_r;
  assign w_inv = ocenv_pkg::WEIGHT_ONE - w_sat;

  always_comb begin
    for (int k = 0; k < NCELL; k++) begin
      mul_start[k] = (state_r == ocenv_pkg::ST_LOAD);
      mul_a[k] = diff[k];
      mul_b[k] = ocenv_pkg::sat_coeff(rise_now[k] ? rise_c[k] : fall_c[k]);
      if (state_r == ocenv_pkg::ST_BLEND && k < 2) begin
        mul_start[k] = 1'b1;
        mul_a[k] = lvl_r[k];
        mul_b[k] = (k == 0) ? CW'(w_sat) : CW'(w_inv);
      end
    end
  end

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    assign rise_now[k] = target > lvl_r[k];
    assign diff[k] = rise_now[k] ? (target - lvl_r[k]) : (lvl_r[k] - target);

    assign lvl_nxt[k] = rise_r[k] ? lvl_r[k] + mul_p[k][ocenv_pkg::FRAC_C +: LW]
                                  : lvl_r[k] - mul_p[k][ocenv_pkg::FRAC_C +: LW];

    ocenv_smul #(.A_W(LW), .B_W(CW)) u_mul (
      .clk   (clk),
      .rst_n (rst_n),
      .start (mul_start[k]),
      .a     (mul_a[k]),
      .b     (mul_b[k]),
      .busy  (mul_busy[k]),
      .prod  (mul_p[k])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        lvl_r[k] <= '0;
      end else if (lvl_upd) begin
        lvl_r[k] <= lvl_nxt[k];
      end
    end
  end

  assign any_busy = |mul_busy;
  assign mix_sum  = mul_p[0][47:0] + mul_p[1][47:0];

  always_comb begin
    state_nxt = state_r;
    in_take   = 1'b0;
    out_load  = 1'b0;
    lvl_upd   = 1'b0;
    unique case (state_r)
      ocenv_pkg::ST_IDLE: begin
        if (in_bus.valid) begin
          in_take   = 1'b1;
          state_nxt = ocenv_pkg::ST_LOAD;
        end
      end
      ocenv_pkg::ST_LOAD: begin
        state_nxt = ocenv_pkg::ST_FOLLOW;
      end
      ocenv_pkg::ST_FOLLOW: begin
        if (!any_busy) begin
          lvl_upd   = 1'b1;
          state_nxt = ocenv_pkg::ST_BLEND;
        end
      end
      ocenv_pkg::ST_BLEND: begin
        state_nxt = ocenv_pkg::ST_MIX;
      end
      ocenv_pkg::ST_MIX: begin
        if (!any_busy) begin
          state_nxt = ocenv_pkg::ST_FINISH;
        end
      end
      ocenv_pkg::ST_FINISH: begin
        if (!out_valid_r || out_bus.ready) begin
          out_load  = 1'b1;
          state_nxt = ocenv_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ocenv_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ocenv_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // clamp target to 0..1.0 on the input beat
  always_ff @(posedge clk) begin
    if (in_take) begin
      srel_r <= in_bus.slow_release_coeff;
      if (in_bus.target_light[ocenv_pkg::LIGHT_W-1]) begin
        tgt_r <= '0;
      end else if (in_bus.target_light[15:0] > ocenv_pkg::LIGHT_ONE) begin
        tgt_r <= ocenv_pkg::LIGHT_ONE;
      end else begin
        tgt_r <= in_bus.target_light[15:0];
      end
    end
    if (state_r == ocenv_pkg::ST_LOAD) begin
      rise_r <= rise_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      blend_r  <= mix_sum[47:32];
      memlvl_r <= lvl_r[2][LW-1 -: ocenv_pkg::OUT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r   <= CW'(38000);
      fast_rel_r <= CW'(6340);
      slow_atk_r <= CW'(38000);
      mem_rise_r <= CW'(380);
      mem_fall_r <= CW'(76);
      weight_r   <= ocenv_pkg::WEIGHT_W'(32768);
    end else if (cfg_bus.valid) begin
      unique case (ocenv_pkg::cfg_reg_t'(cfg_bus.index))
        ocenv_pkg::REG_ATTACK:      attack_r   <= cfg_bus.data;
        ocenv_pkg::REG_FAST_REL:    fast_rel_r <= cfg_bus.data;
        ocenv_pkg::REG_SLOW_ATK:    slow_atk_r <= cfg_bus.data;
        ocenv_pkg::REG_MEM_RISE:    mem_rise_r <= cfg_bus.data;
        ocenv_pkg::REG_MEM_FALL:    mem_fall_r <= cfg_bus.data;
        ocenv_pkg::REG_FAST_WEIGHT: weight_r   <= cfg_bus.data[ocenv_pkg::WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_bus.ready          = (state_r == ocenv_pkg::ST_IDLE);
  assign cfg_bus.ready         = 1'b1;
  assign out_bus.valid         = out_valid_r;
  assign out_bus.blended_light = blend_r;
  assign out_bus.memory_level  = memlvl_r;

endmodule

>>> sv/ocenv_smul.sv
module ocenv_smul #(
  parameter int A_W = 32,
  parameter int B_W = 25
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [A_W-1:0]         a,
  input  logic [B_W-1:0]         b,
  output logic                   busy,
  output logic [A_W+B_W-1:0]     prod
);

  localparam int CW = $clog2(B_W + 1);

  logic [A_W-1:0]     a_r;
  logic [B_W-1:0]     b_r;
  logic [A_W+B_W-1:0] acc_r;
  logic [A_W+B_W-1:0] acc_nxt;
  logic [CW-1:0]      cnt_r;

  always_comb begin
    acc_nxt = {acc_r[A_W+B_W-2:0], 1'b0};
    if (b_r[B_W-1]) begin
      acc_nxt = acc_nxt + {{B_W{1'b0}}, a_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CW'(B_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (cnt_r != '0) begin
      acc_r <= acc_nxt;
      b_r   <= {b_r[B_W-2:0], 1'b0};
    end
  end

  assign busy = (cnt_r != '0);
  assign prod = acc_r;

endmodule

>>> sv/ocenv_chk.sv
module ocenv_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ocenv_pkg::OUT_W-1:0]   out_blended,
  input logic [ocenv_pkg::OUT_W-1:0]   out_memory
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_blended) && $stable(out_memory))
    else $error("stalled result changed");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_blended <= ocenv_pkg::LIGHT_ONE && out_memory <= ocenv_pkg::LIGHT_ONE)
    else $error("result above full scale");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind optical_cell_envelope ocenv_chk u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_bus.valid),
  .in_ready    (in_bus.ready),
  .out_valid   (out_bus.valid),
  .out_ready   (out_bus.ready),
  .out_blended (out_bus.blended_light),
  .out_memory  (out_bus.memory_level)
);

>>> tb/sv/ocenv_envelope_check.sv
`timescale 1ns / 100ps

module ocenv_envelope_check
  import ocenv_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ocenv_in_if  in_mon,
  ocenv_out_if out_mon,
  ocenv_cfg_if cfg_mon,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic [OUT_W-1:0] blended;
    logic [OUT_W-1:0] memory;
  } light_pair_t;

  logic [COEFF_W-1:0]  atk_c, fast_rel_c, slow_atk_c, mem_rise_c, mem_fall_c;
  logic [WEIGHT_W-1:0] weight_c;
  logic [LEVEL_W-1:0]  fast_lvl, slow_lvl, mem_lvl;
  light_pair_t         light_due_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic [LEVEL_W-1:0] next_level(input logic [LEVEL_W-1:0] lvl,
                                                    input logic [LEVEL_W-1:0] tgt,
                                                    input logic [COEFF_W-1:0] rise,
                                                    input logic [COEFF_W-1:0] fall);
    logic [COEFF_W-1:0] c;
    logic [63:0]        prod;
    c = (tgt > lvl) ? rise : fall;
    if (c > COEFF_ONE) c = COEFF_ONE;
    if (tgt > lvl) begin
      prod = 64'(c) * 64'(tgt - lvl);
      return lvl + prod[55:24];
    end
    prod = 64'(c) * 64'(lvl - tgt);
    return lvl - prod[55:24];
  endfunction

  task automatic report_fail(input string msg);
    $display("%0t: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    light_pair_t         due;
    int                  light;
    logic [LEVEL_W-1:0]  tgt;
    logic [WEIGHT_W-1:0] w;
    logic [63:0]         mix;
    if (!rst_n) begin
      atk_c      = 25'd38000;
      fast_rel_c = 25'd6340;
      slow_atk_c = 25'd38000;
      mem_rise_c = 25'd380;
      mem_fall_c = 25'd76;
      weight_c   = 17'd32768;
      fast_lvl   = '0;
      slow_lvl   = '0;
      mem_lvl    = '0;
      light_due_q.delete();
    end else begin
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        if (light_due_q.size() == 0) begin
          report_fail($sformatf("result beat %0d/%0d with nothing predicted",
                                out_mon.blended_light, out_mon.memory_level));
        end else begin
          due = light_due_q.pop_front();
          if (out_mon.blended_light !== due.blended)
            report_fail($sformatf("blended_light got %0d expected %0d",
                                  out_mon.blended_light, due.blended));
          if (out_mon.memory_level !== due.memory)
            report_fail($sformatf("memory_level got %0d expected %0d",
                                  out_mon.memory_level, due.memory));
        end
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        light = in_mon.target_light;
        if (light < 0) light = 0;
        else if (light > int'(LIGHT_ONE)) light = int'(LIGHT_ONE);
        tgt = light << 16;
        fast_lvl = next_level(fast_lvl, tgt, atk_c, fast_rel_c);
        slow_lvl = next_level(slow_lvl, tgt, slow_atk_c, in_mon.slow_release_coeff);
        mem_lvl  = next_level(mem_lvl, tgt, mem_rise_c, mem_fall_c);
        w   = (weight_c > WEIGHT_ONE) ? WEIGHT_ONE : weight_c;
        mix = 64'(w) * 64'(fast_lvl) + (64'(WEIGHT_ONE) - 64'(w)) * 64'(slow_lvl);
        due.blended = mix[47:32];
        due.memory  = mem_lvl[31:16];
        light_due_q.push_back(due);
      end
      if (cfg_mon.valid === 1'b1 && cfg_mon.ready === 1'b1) begin
        case (cfg_mon.index)
          REG_ATTACK:      atk_c      = cfg_mon.data;
          REG_FAST_REL:    fast_rel_c = cfg_mon.data;
          REG_SLOW_ATK:    slow_atk_c = cfg_mon.data;
          REG_MEM_RISE:    mem_rise_c = cfg_mon.data;
          REG_MEM_FALL:    mem_fall_c = cfg_mon.data;
          REG_FAST_WEIGHT: weight_c   = cfg_mon.data[WEIGHT_W-1:0];
          default: ;
        endcase
      end
    end
    pending = light_due_q.size();
  end

endmodule

>>> tb/sv/tb_optical_cell_envelope.sv
`timescale 1ns / 100ps

module tb_optical_cell_envelope;
  import ocenv_pkg::*;

  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int DRAIN_CYCLES  = 64;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 140;

  localparam logic [IDX_W-1:0]          REG_SPARE_6 = 3'd6;
  localparam logic [IDX_W-1:0]          REG_SPARE_7 = 3'd7;
  localparam logic [COEFF_W-1:0]        COEFF_MAX   = '1;
  localparam logic signed [LIGHT_W-1:0] LIGHT_MIN   = 17'sh10000;
  localparam logic signed [LIGHT_W-1:0] LIGHT_MAX   = 17'sh0FFFF;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  int   stall_left  = 0;
  bit   calm        = 1'b0;

  ocenv_in_if  in_bus ();
  ocenv_out_if out_bus ();
  ocenv_cfg_if cfg_bus ();

  optical_cell_envelope uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  ocenv_envelope_check chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .cfg_mon    (cfg_bus),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin : sink_pace
    int r;
    if (!rst_n) begin
      out_bus.ready = 1'b0;
    end else if (stall_left > 0) begin
      out_bus.ready = 1'b0;
      stall_left--;
    end else begin
      out_bus.ready = 1'b1;
      r = $urandom_range(0, 99);
      if (!calm) begin
        if (r >= 92) stall_left = $urandom_range(20, 120);
        else if (r >= 70) stall_left = $urandom_range(1, 4);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  function automatic logic signed [LIGHT_W-1:0] pick_light();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return LIGHT_W'($urandom);
    if (r < 24) begin
      case ($urandom_range(0, 5))
        0: return 17'sd0;
        1: return 17'sd32768;
        2: return 17'sd32769;
        3: return LIGHT_MIN;
        4: return LIGHT_MAX;
        default: return -17'sd1;
      endcase
    end
    return LIGHT_W'($urandom_range(0, 32768));
  endfunction

  function automatic logic [COEFF_W-1:0] pick_slow_release();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return COEFF_W'($urandom);
    if (r < 20) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return COEFF_ONE;
        2: return COEFF_ONE + 25'd1;
        default: return COEFF_MAX;
      endcase
    end
    if (r < 50) return COEFF_W'($urandom_range(1, 1 << 20));
    return COEFF_W'($urandom_range(0, 1 << 24));
  endfunction

  function automatic logic [COEFF_W-1:0] pick_coeff();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return COEFF_ONE;
    if (r < 24) return COEFF_W'($urandom_range(COEFF_ONE + 1, COEFF_MAX));
    if (r < 45) return COEFF_W'($urandom_range(1, 1 << 16));
    return COEFF_W'($urandom_range(0, 1 << 24));
  endfunction

  function automatic logic [COEFF_W-1:0] pick_weight_data();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return '0;
    if (r < 24) return COEFF_W'(WEIGHT_ONE);
    if (r < 34) return COEFF_W'($urandom);
    return COEFF_W'($urandom_range(0, 65536));
  endfunction

  task automatic send_light(input logic signed [LIGHT_W-1:0] tl,
                            input logic [COEFF_W-1:0] sc);
    int gap;
    in_bus.valid              = 1'b1;
    in_bus.target_light       = tl;
    in_bus.slow_release_coeff = sc;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [COEFF_W-1:0] val);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = val;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic settle();
    in_bus.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic load_config(input logic [COEFF_W-1:0] atk, input logic [COEFF_W-1:0] frel,
                             input logic [COEFF_W-1:0] satk, input logic [COEFF_W-1:0] mrise,
                             input logic [COEFF_W-1:0] mfall, input logic [COEFF_W-1:0] wgt);
    write_reg(REG_ATTACK, atk);
    write_reg(REG_FAST_REL, frel);
    write_reg(REG_SLOW_ATK, satk);
    write_reg(REG_MEM_RISE, mrise);
    write_reg(REG_MEM_FALL, mfall);
    write_reg(REG_FAST_WEIGHT, wgt);
  endtask

  initial begin : stimulus
    logic signed [LIGHT_W-1:0] hold_light;
    logic [COEFF_W-1:0]        hold_rel;
    rst_n                     = 1'b0;
    in_bus.valid              = 1'b0;
    in_bus.target_light       = '0;
    in_bus.slow_release_coeff = '0;
    cfg_bus.valid             = 1'b0;
    cfg_bus.index             = '0;
    cfg_bus.data              = '0;
    out_bus.ready             = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_light(17'sd0, 25'd0);
    send_light(17'sd32768, COEFF_ONE);
    send_light(LIGHT_MAX, 25'd0);
    send_light(LIGHT_MIN, COEFF_MAX);
    send_light(-17'sd1, 25'd1);
    send_light(17'sd32769, COEFF_ONE + 25'd1);
    send_light(17'sd1, 25'd12345);
    send_light(17'sd32767, COEFF_ONE);

    settle();
    load_config(COEFF_ONE, COEFF_ONE, COEFF_ONE, COEFF_ONE, COEFF_ONE, COEFF_W'(WEIGHT_ONE));
    send_light(17'sd32768, 25'd0);
    send_light(17'sd0, COEFF_ONE);
    send_light(17'sd16384, 25'd0);

    settle();
    load_config(COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX);
    send_light(17'sd32768, COEFF_MAX);
    send_light(LIGHT_MIN, COEFF_MAX);
    send_light(17'sd20000, COEFF_ONE);

    settle();
    load_config('0, '0, '0, '0, '0, '0);
    send_light(17'sd32768, 25'd0);
    send_light(17'sd32768, 25'd0);
    send_light(17'sd0, 25'd0);

    settle();
    write_reg(REG_SPARE_6, COEFF_MAX);
    write_reg(REG_SPARE_7, 25'd1);
    load_config(25'd38000, 25'd6340, 25'd38000, 25'd380, 25'd76, 25'd12345);
    send_light(17'sd32768, 25'd1000);
    send_light(17'sd100, 25'd50);
    send_light(-17'sd100, 25'h155_5555);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      calm = ($urandom_range(0, 3) == 0);
      load_config(pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff(),
                  pick_weight_data());
      if ($urandom_range(0, 2) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, COEFF_W'($urandom));
      hold_light = pick_light();
      hold_rel   = pick_slow_release();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 7) == 0) hold_light = pick_light();
        if ($urandom_range(0, 5) == 0) hold_rel = pick_slow_release();
        if ($urandom_range(0, 9) == 0)
          send_light(LIGHT_W'($urandom), COEFF_W'($urandom));
        else
          send_light(hold_light, hold_rel);
      end
    end

    in_bus.valid = 1'b0;
    calm = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

>>> files.f
sv/ocenv_pkg.sv
sv/ocenv_if.sv
sv/ocenv_smul.sv
sv/optical_cell_envelope.sv
sv/ocenv_chk.sv
tb/sv/ocenv_envelope_check.sv
tb/sv/tb_optical_cell_envelope.sv
